// ===== hdl/crc32_frame_receiver_top_defines.svh =====
// Assertion macros shared by the frame receiver modules.
`ifndef CRC32_FRAME_RECEIVER_TOP_DEFINES_SVH
`define CRC32_FRAME_RECEIVER_TOP_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define CRCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define CRCFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/crcfr_pkg.sv =====
package crcfr_pkg;

  localparam int unsigned FLAG_BYTES = 4;
  localparam int unsigned HDR_BYTES  = 13;
  localparam int unsigned RESQ_DEPTH = 4;
  localparam int unsigned RESQ_AW    = $clog2(RESQ_DEPTH);
  localparam int unsigned CFG_AW     = 4;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] FLAG_RESET   = 32'h7465_7374;
  localparam logic [15:0] MAXLEN_RESET = 16'd4096;
  localparam logic [31:0] SEED_RESET   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    REG_FLAG   = 2'd0,
    REG_MAXLEN = 2'd1,
    REG_SEED   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_PAYLOAD  = 3'd1,
    KIND_GOOD     = 3'd2,
    KIND_PCRC_BAD = 3'd3,
    KIND_HCRC_BAD = 3'd4,
    KIND_LEN_BAD  = 3'd5
  } kind_t;

  typedef struct packed {
    logic [31:0] flag_pattern;
    logic [15:0] max_payload_len;
    logic [31:0] crc_seed;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  frame_type;
    logic [31:0] payload_len;
    logic [31:0] frame_offset;
    logic [7:0]  payload_byte;
    logic        last;
  } res_t;

  typedef struct packed {
    logic p0;
    logic p1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== hdl/crcfr_cfg.sv =====
module crcfr_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crcfr_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output crcfr_pkg::cfg_t               cfg
);

  localparam int unsigned CFG_AW_HI = crcfr_pkg::CFG_AW - 1;

  crcfr_pkg::cfg_t   cfg_r;
  crcfr_pkg::cfg_t   cfg_nxt;
  crcfr_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = crcfr_pkg::reg_idx_t'(paddr[CFG_AW_HI:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        crcfr_pkg::REG_FLAG:   cfg_nxt.flag_pattern    = pwdata;
        crcfr_pkg::REG_MAXLEN: cfg_nxt.max_payload_len = pwdata[15:0];
        crcfr_pkg::REG_SEED:   cfg_nxt.crc_seed        = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      crcfr_pkg::REG_FLAG:   prdata = cfg_r.flag_pattern;
      crcfr_pkg::REG_MAXLEN: prdata = {16'b0, cfg_r.max_payload_len};
      crcfr_pkg::REG_SEED:   prdata = cfg_r.crc_seed;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_pattern    <= crcfr_pkg::FLAG_RESET;
      cfg_r.max_payload_len <= crcfr_pkg::MAXLEN_RESET;
      cfg_r.crc_seed        <= crcfr_pkg::SEED_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== hdl/crcfr_core.sv =====
`include "crc32_frame_receiver_top_defines.svh"

module crcfr_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_rx_byte,
  input  crcfr_pkg::cfg_t   cfg,
  input  logic              room,
  output crcfr_pkg::push_t  push
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ crcfr_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_byte_r, in_byte_nxt;
  logic        fire;
  logic        accept;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  flag_cnt_r, flag_cnt_nxt;
  logic [3:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  hdr_type_r, hdr_type_nxt;
  logic [31:0] hdr_len_r, hdr_len_nxt;
  logic [31:0] hdr_off_r, hdr_off_nxt;
  logic [31:0] rx_crc_r, rx_crc_nxt;
  logic [31:0] run_crc_r, run_crc_nxt;
  logic [16:0] remain_r, remain_nxt;

  logic        emit0, emit1;
  crcfr_pkg::kind_t k0, k1;
  logic [7:0]  pbyte;
  logic [7:0]  flag_byte;

  assign fire     = in_vld_r & room;
  assign in_stall = in_vld_r & ~room;
  assign accept   = in_valid & ~in_stall;

  assign flag_byte = cfg.flag_pattern[{~flag_cnt_r, 3'b000} +: 8];

  always_comb begin
    in_vld_nxt  = accept ? 1'b1 : (fire ? 1'b0 : in_vld_r);
    in_byte_nxt = accept ? in_rx_byte : in_byte_r;
  end

  always_comb begin
    phase_nxt    = phase_r;
    flag_cnt_nxt = flag_cnt_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    hdr_type_nxt = hdr_type_r;
    hdr_len_nxt  = hdr_len_r;
    hdr_off_nxt  = hdr_off_r;
    rx_crc_nxt   = rx_crc_r;
    run_crc_nxt  = run_crc_r;
    remain_nxt   = remain_r;
    emit0        = 1'b0;
    emit1        = 1'b0;
    k0           = crcfr_pkg::KIND_HEADER;
    k1           = crcfr_pkg::KIND_GOOD;
    pbyte        = 8'd0;
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_cnt_r == 4'd0) begin
            hdr_type_nxt = in_byte_r;
          end else if (hdr_cnt_r <= 4'd4) begin
            hdr_len_nxt = {in_byte_r, hdr_len_r[31:8]};
          end else if (hdr_cnt_r <= 4'd8) begin
            hdr_off_nxt = {in_byte_r, hdr_off_r[31:8]};
          end else begin
            rx_crc_nxt = {in_byte_r, rx_crc_r[31:8]};
          end
          if (hdr_cnt_r <= 4'd8) begin
            run_crc_nxt = crc_byte(run_crc_r, in_byte_r);
          end
          if (hdr_cnt_r >= 4'(crcfr_pkg::HDR_BYTES - 1)) begin
            hdr_cnt_nxt = 4'd0;
            phase_nxt   = PH_HUNT;
            emit0       = 1'b1;
            if (rx_crc_nxt != run_crc_nxt) begin
              k0 = crcfr_pkg::KIND_HCRC_BAD;
            end else if (hdr_len_nxt > {16'b0, cfg.max_payload_len}) begin
              k0 = crcfr_pkg::KIND_LEN_BAD;
            end else begin
              k0 = crcfr_pkg::KIND_HEADER;
              if (hdr_len_nxt == 32'd0) begin
                emit1 = 1'b1;
                k1    = crcfr_pkg::KIND_GOOD;
              end else begin
                phase_nxt   = PH_PAYLOAD;
                remain_nxt  = hdr_len_nxt[16:0] + 17'd4;
                run_crc_nxt = cfg.crc_seed;
                rx_crc_nxt  = '0;
              end
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 4'd1;
          end
        end
        PH_PAYLOAD: begin
          if (remain_r > 17'd4) begin
            run_crc_nxt = crc_byte(run_crc_r, in_byte_r);
            emit0       = 1'b1;
            k0          = crcfr_pkg::KIND_PAYLOAD;
            pbyte       = in_byte_r;
            remain_nxt  = remain_r - 17'd1;
          end else begin
            rx_crc_nxt = {in_byte_r, rx_crc_r[31:8]};
            if (remain_r != 17'd0) begin
              remain_nxt = remain_r - 17'd1;
            end
            if (remain_r <= 17'd1) begin
              emit0     = 1'b1;
              k0        = (rx_crc_nxt == run_crc_r) ? crcfr_pkg::KIND_GOOD
                                                    : crcfr_pkg::KIND_PCRC_BAD;
              phase_nxt = PH_HUNT;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (in_byte_r == flag_byte) begin
            if ({1'b0, flag_cnt_r} + 3'd1 >= 3'(crcfr_pkg::FLAG_BYTES)) begin
              flag_cnt_nxt = 2'd0;
              phase_nxt    = PH_HEADER;
              hdr_cnt_nxt  = 4'd0;
              run_crc_nxt  = cfg.crc_seed;
            end else begin
              flag_cnt_nxt = flag_cnt_r + 2'd1;
            end
          end else begin
            flag_cnt_nxt = 2'd0;
          end
        end
      endcase
    end
  end

  always_comb begin
    push.p0              = emit0;
    push.p1              = emit1;
    push.r0.kind         = k0;
    push.r0.frame_type   = hdr_type_nxt;
    push.r0.payload_len  = hdr_len_nxt;
    push.r0.frame_offset = hdr_off_nxt;
    push.r0.payload_byte = pbyte;
    push.r0.last         = ~emit1;
    push.r1.kind         = k1;
    push.r1.frame_type   = hdr_type_nxt;
    push.r1.payload_len  = hdr_len_nxt;
    push.r1.frame_offset = hdr_off_nxt;
    push.r1.payload_byte = 8'd0;
    push.r1.last         = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      in_byte_r  <= 8'd0;
      phase_r    <= PH_HUNT;
      flag_cnt_r <= 2'd0;
      hdr_cnt_r  <= 4'd0;
      hdr_type_r <= 8'd0;
      hdr_len_r  <= 32'd0;
      hdr_off_r  <= 32'd0;
      rx_crc_r   <= 32'd0;
      run_crc_r  <= crcfr_pkg::SEED_RESET;
      remain_r   <= 17'd0;
    end else begin
      in_vld_r   <= in_vld_nxt;
      in_byte_r  <= in_byte_nxt;
      phase_r    <= phase_nxt;
      flag_cnt_r <= flag_cnt_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      hdr_type_r <= hdr_type_nxt;
      hdr_len_r  <= hdr_len_nxt;
      hdr_off_r  <= hdr_off_nxt;
      rx_crc_r   <= rx_crc_nxt;
      run_crc_r  <= run_crc_nxt;
      remain_r   <= remain_nxt;
    end
  end

  `CRCFR_ASSERT(a_payload_remain, (phase_r != PH_PAYLOAD) || (remain_r != 17'd0), "payload phase with nothing remaining")
  `CRCFR_ASSERT(a_hold_request, in_vld_r && !room |=> in_vld_r && $stable(in_byte_r), "held request lost or changed")

endmodule

// ===== hdl/crcfr_resq.sv =====
`include "crc32_frame_receiver_top_defines.svh"

module crcfr_resq (
  input  logic             clk,
  input  logic             rst_n,
  input  crcfr_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output crcfr_pkg::res_t  head
);

  localparam int unsigned AW = crcfr_pkg::RESQ_AW;
  localparam int unsigned CW = crcfr_pkg::RESQ_AW + 1;

  crcfr_pkg::res_t q_r [crcfr_pkg::RESQ_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid & ~out_stall;
  assign room      = cnt_r <= CW'(crcfr_pkg::RESQ_DEPTH - 2);
  assign head      = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(push.p0) + AW'(push.p1);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(push.p0) + CW'(push.p1) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.p0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.p1) begin
      q_r[wr_ptr_r + AW'(1)] <= push.r1;
    end
  end

  `CRCFR_ASSERT(a_cnt_bound, cnt_r <= CW'(crcfr_pkg::RESQ_DEPTH), "result queue overflow")
  `CRCFR_ASSERT_IMPL(a_push_order, push.p1, push.p0, "second result without first")
  `CRCFR_ASSERT_IMPL(a_push_room, push.p0, room, "result pushed without room")

endmodule

// ===== hdl/crc32_frame_receiver_top.sv =====
// Flag-delimited frame receiver with CRC-32 checks. Takes one received byte per
// cycle while in_stall is low: a byte is held in an input register and is
// decoded from there once the result queue has room, and its results (at most
// two, the second only for a zero-length frame) go to a four-entry result queue
// that drives the out_ ports. in_stall rises only while a byte waits in the
// input register and the result queue holds three or more results, which
// happens only after the out side has been stalled; with no back-pressure the
// block sustains one byte per cycle. The CRC is the reflected CRC-32
// (0xEDB88320) with a byte-wide update and no final inversion, seeded from
// crc_seed at each flag and each payload start.
// Write the registers only while the block is idle.
module crc32_frame_receiver_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_frame_type,
  output logic [31:0] out_payload_len,
  output logic [31:0] out_frame_offset,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  crcfr_pkg::cfg_t  cfg;
  crcfr_pkg::push_t push;
  crcfr_pkg::res_t  head;
  logic             room;

  crcfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  crcfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .cfg        (cfg),
    .room       (room),
    .push       (push)
  );

  crcfr_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind         = head.kind;
  assign out_frame_type   = head.frame_type;
  assign out_payload_len  = head.payload_len;
  assign out_frame_offset = head.frame_offset;
  assign out_payload_byte = head.payload_byte;
  assign out_last         = head.last;

endmodule
